// File: rtl/cba_pkg.sv
// shared types and constants for the contiguous block allocator
package cba_pkg;

  localparam int DEF_NUM_BLOCKS = 128;
  localparam int FIELD_W        = 7;
  localparam int FIELD_MAX      = 127;
  localparam int STATUS_W       = 2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic wr_bit;
  } map_ctl_t;

endpackage

// File: rtl/cba_map.sv
// circular shift register holding the free map, one block per cycle at the tap while ctl.shift is set
module cba_map import cba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic     clk,
  input  logic     rst,
  input  map_ctl_t ctl,
  output logic     cur_bit
);

  logic [NUM_BLOCKS-1:0] map;

  // block 0 reserved, all others free
  localparam logic [NUM_BLOCKS-1:0] MAP_RESET = {{(NUM_BLOCKS-1){1'b1}}, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      map <= MAP_RESET;
    end else if (ctl.shift) begin
      map <= {ctl.wr_bit, map[NUM_BLOCKS-1:1]};
    end
  end

  assign cur_bit = map[0];

endmodule

// File: rtl/cba_ctrl.sv
// request sequencer: validation, first-fit scan pass, mark pass and result register
module cba_ctrl import cba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                req_kind,
  input  logic [FIELD_W-1:0]  req_first,
  input  logic [FIELD_W-1:0]  req_count,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [STATUS_W-1:0] res_status,
  output logic [FIELD_W-1:0]  res_start,
  input  logic                cur_bit,
  output map_ctl_t            map_ctl
);

  localparam int CW   = $clog2(NUM_BLOCKS);
  localparam int CMPW = (CW > FIELD_W + 1) ? CW : FIELD_W + 1;
  localparam int TOP  = (NUM_BLOCKS - 1 < FIELD_MAX) ? NUM_BLOCKS - 1 : FIELD_MAX;
  localparam logic [CW-1:0]   IDX_LAST = CW'(NUM_BLOCKS - 1);
  localparam logic [CMPW-1:0] TOP_X    = CMPW'(TOP);

  state_t state, state_next;

  logic [CW-1:0]       idx;
  logic                kind;
  logic [FIELD_W-1:0]  count;
  logic [FIELD_W-1:0]  lo;
  logic [FIELD_W-1:0]  run;
  logic [FIELD_W-1:0]  run_start;
  logic                found;
  logic [STATUS_W-1:0] status;

  logic                accept;
  logic                bad_req;
  logic [FIELD_W:0]    free_end;
  logic [CMPW-1:0]     idx_x;
  logic [CMPW-1:0]     lo_x;
  logic [CMPW-1:0]     hi_x;
  logic                in_range;
  logic                mark_hit;
  logic                pass_end;
  logic                res_load;
  logic                scan_hit;
  logic                found_now;
  logic [FIELD_W-1:0]  start_now;

  assign accept   = req_valid && req_ready;
  assign free_end = {1'b0, req_first} + {1'b0, req_count};

  always_comb begin
    if (req_kind == KIND_ALLOC) begin
      bad_req = (req_count == '0) || (CMPW'(req_count) > TOP_X);
    end else begin
      bad_req = (req_count == '0) || (req_first == '0) ||
                (CMPW'(free_end) > TOP_X + CMPW'(1));
    end
  end

  assign idx_x    = CMPW'(idx);
  assign lo_x     = CMPW'(lo);
  assign hi_x     = CMPW'({1'b0, lo} + {1'b0, count});
  assign in_range = (idx != '0) && (idx_x <= TOP_X);
  assign mark_hit = (idx_x >= lo_x) && (idx_x < hi_x);
  assign pass_end = (idx == IDX_LAST);
  assign res_load = (state == S_DONE) && (!res_valid || res_ready);

  // run completed at the tap this cycle, including the last block of the pass
  assign scan_hit  = in_range && !found && cur_bit && (run + FIELD_W'(1) == count);
  assign found_now = found || scan_hit;
  assign start_now = (run == '0) ? FIELD_W'(idx) : run_start;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (bad_req) begin
            state_next = S_DONE;
          end else if (req_kind == KIND_ALLOC) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_MARK;
          end
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          state_next = found_now ? S_MARK : S_DONE;
        end
      end
      S_MARK: begin
        if (pass_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready      = 1'b0;
    map_ctl.shift  = 1'b0;
    map_ctl.wr_bit = cur_bit;
    case (state)
      S_IDLE: req_ready = 1'b1;
      S_SCAN: map_ctl.shift = 1'b1;
      S_MARK: begin
        map_ctl.shift = 1'b1;
        if (mark_hit) begin
          map_ctl.wr_bit = (kind == KIND_FREE);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == S_SCAN || state == S_MARK) begin
      idx <= pass_end ? '0 : idx + CW'(1);
    end else begin
      idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= req_kind;
      count     <= req_count;
      lo        <= req_first;
      run       <= '0;
      run_start <= '0;
      found     <= 1'b0;
      status    <= bad_req ? ST_BAD : ST_OK;
    end else if (state == S_SCAN) begin
      if (in_range && !found) begin
        if (cur_bit) begin
          if (run == '0) begin
            run_start <= FIELD_W'(idx);
          end
          run <= run + FIELD_W'(1);
          if (run + FIELD_W'(1) == count) begin
            found <= 1'b1;
          end
        end else begin
          run <= '0;
        end
      end
      if (pass_end) begin
        if (found_now) begin
          lo <= found ? run_start : start_now;
        end else begin
          status <= ST_NO_ROOM;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= status;
      res_start  <= (status == ST_OK && kind == KIND_ALLOC) ? lo : '0;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == ST_OK || res_status == ST_NO_ROOM || res_status == ST_BAD))
    else $error("result status outside the defined codes");

  a_start_only_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_start != '0) |-> (res_status == ST_OK))
    else $error("nonzero run start on a failed request");

  a_scan_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pass_end && !found_now) |=> (state == S_DONE && status == ST_NO_ROOM))
    else $error("failed scan did not report no room");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle right after taking a request");

endmodule

// File: rtl/contiguous_block_allocator.sv
// top level of the first-fit contiguous block allocator
//
//   channel | direction | contents
//   s_*     | in        | tuser: kind; tdata: first_block, block_count
//   m_*     | out       | tuser: status; tdata: run_start
//
// bad request: goes from accept straight to the done state and the result register
// free or allocate with no room: one rotation of the free map
// allocate: a scan rotation then a mark rotation
// one map bit passes the tap per cycle during a scan or mark pass; a new request is taken once the result is registered
// rst restores the map at once: block 0 used, all others free
// a stalled result holds in the output register while the next request is taken
module contiguous_block_allocator import cba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] first_block, [13:7] block_count, [15:14] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] run_start, [7] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  map_ctl_t           map_ctl;
  logic               cur_bit;
  logic [FIELD_W-1:0] res_start;

  cba_map #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .cur_bit (cur_bit)
  );

  cba_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_kind   (s_tuser),
    .req_first  (s_tdata[6:0]),
    .req_count  (s_tdata[13:7]),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_status (m_tuser),
    .res_start  (res_start),
    .cur_bit    (cur_bit),
    .map_ctl    (map_ctl)
  );

  assign m_tdata = {1'b0, res_start};

endmodule

// File: tb/contiguous_block_allocator_test.sv
// self-checking stream testbench for the contiguous block allocator
`timescale 1ns / 100ps

module contiguous_block_allocator_test;
  import cba_pkg::*;

  localparam int NUM_BLOCKS   = DEF_NUM_BLOCKS;
  localparam int TOP_BLOCK    = (NUM_BLOCKS - 1 < FIELD_MAX) ? NUM_BLOCKS - 1 : FIELD_MAX;
  localparam int RANDOM_ITEMS = 1426;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 10;
  localparam int HOLD_OFF     = 1500;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  run_start;
  } reply_t;

  typedef struct packed {
    logic                kind;
    logic [FIELD_W-1:0]  first_block;
    logic [FIELD_W-1:0]  block_count;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  run_start;
  } script_row_t;

  typedef struct {
    int start_blk;
    int len;
  } held_run_t;

  localparam script_row_t DIRECTED [0:23] = '{
    '{KIND_ALLOC, 7'd0,   7'd0,   1'b1, ST_BAD,     7'd0},
    '{KIND_ALLOC, 7'd0,   7'd127, 1'b1, ST_OK,      7'd1},
    '{KIND_ALLOC, 7'd0,   7'd1,   1'b1, ST_NO_ROOM, 7'd0},
    '{KIND_FREE,  7'd0,   7'd5,   1'b1, ST_BAD,     7'd0},
    '{KIND_FREE,  7'd1,   7'd0,   1'b1, ST_BAD,     7'd0},
    '{KIND_FREE,  7'd101, 7'd28,  1'b1, ST_BAD,     7'd0},
    '{KIND_FREE,  7'd127, 7'd127, 1'b1, ST_BAD,     7'd0},
    '{KIND_FREE,  7'd127, 7'd1,   1'b1, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd0,   7'd1,   1'b0, ST_OK,      7'd0},
    '{KIND_FREE,  7'd1,   7'd127, 1'b1, ST_OK,      7'd0},
    '{KIND_FREE,  7'd5,   7'd3,   1'b1, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd127, 7'd0,   1'b1, ST_BAD,     7'd0},
    '{KIND_ALLOC, 7'd127, 7'd127, 1'b1, ST_OK,      7'd1},
    '{KIND_FREE,  7'd10,  7'd20,  1'b1, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd0,   7'd21,  1'b1, ST_NO_ROOM, 7'd0},
    '{KIND_ALLOC, 7'd0,   7'd20,  1'b0, ST_OK,      7'd0},
    '{KIND_FREE,  7'd0,   7'd0,   1'b1, ST_BAD,     7'd0},
    '{KIND_FREE,  7'd1,   7'd127, 1'b1, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd127, 7'd5,   1'b0, ST_OK,      7'd0},
    '{KIND_FREE,  7'd3,   7'd1,   1'b1, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd0,   7'd1,   1'b0, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd0,   7'd2,   1'b0, ST_OK,      7'd0},
    '{KIND_ALLOC, 7'd0,   7'd120, 1'b0, ST_OK,      7'd0},
    '{KIND_FREE,  7'd1,   7'd127, 1'b1, ST_OK,      7'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [6:0] first_block, [13:7] block_count, [15:14] zero
  logic        s_tuser;   // [0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [6:0] run_start, [7] zero
  logic [1:0]  m_tuser;   // [1:0] status

  logic [NUM_BLOCKS-1:0] model_map;
  reply_t                expected_replies [$];
  held_run_t             held_runs [$];
  int                    mismatches = 0;
  int                    replies_seen;
  int                    cycle_count = 0;

  contiguous_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 80);
  endfunction

  // first-fit allocate or free on the free map copy
  function automatic reply_t predict_block_request(input logic kind,
                                                   input logic [FIELD_W-1:0] first_block,
                                                   input logic [FIELD_W-1:0] block_count);
    reply_t rep;
    int     run_len;
    int     run_at;
    int     b;
    int     cnt;
    int     fb;
    bit     found;
    rep.status    = ST_OK;
    rep.run_start = '0;
    cnt = int'(block_count);
    fb  = int'(first_block);
    if (kind == KIND_ALLOC) begin
      if (cnt == 0 || cnt > TOP_BLOCK) begin
        rep.status = ST_BAD;
      end else begin
        run_len = 0;
        run_at  = 0;
        found   = 1'b0;
        for (b = 1; b <= TOP_BLOCK && !found; b++) begin
          if (model_map[b]) begin
            if (run_len == 0) run_at = b;
            run_len++;
            if (run_len == cnt) found = 1'b1;
          end else begin
            run_len = 0;
          end
        end
        if (found) begin
          for (b = run_at; b < run_at + cnt; b++) model_map[b] = 1'b0;
          rep.run_start = FIELD_W'(run_at);
        end else begin
          rep.status = ST_NO_ROOM;
        end
      end
    end else begin
      if (cnt == 0 || fb == 0 || fb + cnt - 1 > TOP_BLOCK) begin
        rep.status = ST_BAD;
      end else begin
        for (b = fb; b < fb + cnt; b++) model_map[b] = 1'b1;
      end
    end
    return rep;
  endfunction

  task automatic send_request(input logic kind, input logic [FIELD_W-1:0] first_block,
                              input logic [FIELD_W-1:0] block_count, input bit typed,
                              input reply_t typed_reply, input int gap);
    reply_t rep;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, block_count, first_block};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rep = predict_block_request(kind, first_block, block_count);
    expected_replies.push_back(typed ? typed_reply : rep);
    if (kind == KIND_ALLOC && rep.status == ST_OK) begin
      held_runs.push_back('{int'(rep.run_start), int'(block_count)});
    end
  endtask

  task automatic pick_random_request(output logic kind, output logic [FIELD_W-1:0] first_block,
                                     output logic [FIELD_W-1:0] block_count);
    int        r;
    int        sz;
    int        idx;
    held_run_t hr;
    r = $urandom_range(0, 99);
    if (r >= 45 && r < 80 && held_runs.size() == 0) r = 0;
    if (r < 45) begin
      sz = $urandom_range(0, 99);
      kind        = KIND_ALLOC;
      first_block = FIELD_W'($urandom_range(0, FIELD_MAX));
      if (sz < 80) begin
        block_count = FIELD_W'($urandom_range(1, 12));
      end else if (sz < 95) begin
        block_count = FIELD_W'($urandom_range(13, 64));
      end else begin
        block_count = FIELD_W'($urandom_range(65, FIELD_MAX));
      end
    end else if (r < 80) begin
      idx = $urandom_range(0, held_runs.size() - 1);
      hr  = held_runs[idx];
      held_runs.delete(idx);
      kind        = KIND_FREE;
      first_block = FIELD_W'(hr.start_blk);
      block_count = FIELD_W'(hr.len);
      // partial release of an owned run
      if ($urandom_range(0, 4) == 0) block_count = FIELD_W'($urandom_range(1, hr.len));
    end else if (r < 82) begin
      kind        = KIND_FREE;
      first_block = 7'd1;
      block_count = FIELD_W'(FIELD_MAX);
      held_runs.delete();
    end else if (r < 90) begin
      kind        = KIND_FREE;
      first_block = FIELD_W'($urandom_range(0, FIELD_MAX));
      block_count = FIELD_W'($urandom_range(0, FIELD_MAX));
    end else begin
      kind        = logic'($urandom_range(0, 1));
      first_block = FIELD_W'($urandom_range(0, FIELD_MAX));
      block_count = FIELD_W'($urandom_range(0, FIELD_MAX));
    end
  endtask

  initial begin
    script_row_t              row;
    logic                     kind;
    logic [FIELD_W-1:0]       first_block;
    logic [FIELD_W-1:0]       block_count;
    int                       gap;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    model_map    = '1;
    model_map[0] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_request(row.kind, row.first_block, row.block_count, row.typed,
                   '{row.status, row.run_start}, draw_gap());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random_request(kind, first_block, block_count);
      // stretches with the sender never idling
      gap = ((n / 200) % 3 == 1) ? 0 : draw_gap();
      send_request(kind, first_block, block_count, 1'b0, '0, gap);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("contiguous_block_allocator test passed");
    end else begin
      $display("contiguous_block_allocator test failed");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off to fill the block
  initial begin
    int stall_left;
    bit held_off;
    m_tready   = 1'b0;
    stall_left = 0;
    held_off   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_off && replies_seen >= 300) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ((replies_seen / 200) % 3 != 2) begin
          if (m_tvalid ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 49) == 0)) begin
            stall_left = draw_gap();
          end
        end
      end
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst) begin
      replies_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      replies_seen <= replies_seen + 1;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status %0d run_start %0d",
                                  m_tuser, m_tdata[6:0]));
      end else begin
        want = expected_replies.pop_front();
        if (m_tuser !== want.status) begin
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_seen, m_tuser, want.status));
        end
        if (m_tdata[6:0] !== want.run_start) begin
          report_mismatch($sformatf("reply %0d run_start %0d, want %0d",
                                    replies_seen, m_tdata[6:0], want.run_start));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("contiguous_block_allocator test failed");
      $finish;
    end
  end

endmodule
